// ===== sv/ozd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the observed zone dedup FIFO.
package ozd_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int ZONE_W  = 16;
  localparam int IDX_W   = 3;
  localparam int ECNT_W  = 4;
  localparam int CFG_IDX_W = 1;

  // Operation codes.
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_MAX = 1'b1;

  localparam logic signed [ZONE_W-1:0] ZONE_MIN_RST = 16'sd0;
  localparam logic signed [ZONE_W-1:0] ZONE_MAX_RST = 16'sd255;

  // Physical slot of logical position off, counted from the oldest slot base.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
      sum = sum - (CNT_W+1)'(MAX_ENTRIES);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // True when the read position lies below the fill count.
  function automatic logic idx_below(input logic [IDX_W-1:0] idx,
                                     input logic [CNT_W-1:0] cnt);
    logic [IDX_W+CNT_W-1:0] a;
    logic [IDX_W+CNT_W-1:0] b;
    a = (IDX_W+CNT_W)'(idx);
    b = (IDX_W+CNT_W)'(cnt);
    return a < b;
  endfunction

  // Fill count as shown on the 4-bit result field.
  function automatic logic [ECNT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+ECNT_W-1:0] ext;
    ext = (CNT_W+ECNT_W)'(cnt);
    return ext[ECNT_W-1:0];
  endfunction

endpackage

// ===== sv/observed_zone_dedup_fifo.sv =====
`timescale 1ns / 1ps
// Top level of the observed zone dedup FIFO: sequencer around the zone RAM.
//
// Keeps up to MAX_ENTRIES distinct zones in order of first sighting.
// Command channel: an item is taken at a clock edge with start high and
// busy low. Operation observe checks the zone against the configured
// range, scans the list for it and appends it when new (dropping the
// oldest zone when full). Operation read returns the entry at read_index.
// Every item gives one result, shown for one cycle with done_o high; the
// receiver cannot stall, so results are never held back.
// Sequence from the accepting edge: observe goes through S_CHECK, which
// answers when the zone is out of range; else S_SCAN and S_CMP alternate
// per held entry until a duplicate is found (result from S_CMP) or the
// whole list is compared (append and result from S_WRITE).
// The scan reads one RAM entry and compares it in the next cycle, so the
// RAM read port sets the rate.
// Read answers from S_RDISS, or from S_RDWAIT when the index hits an entry.
// One item at a time: busy stays high from accept until the result shows,
// and a new item may start in the cycle that done_o is high.
// The list lives in a circular RAM (head slot plus fill count).
// Reset empties the list at once by clearing the count; the RAM itself
// is not cleared, since only entries below the count are ever read.
// Configuration writes (zone_min, zone_max) must be made while idle; the block does not enforce this.
module observed_zone_dedup_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation_i,
  input  logic signed [ozd_pkg::ZONE_W-1:0]    zone_i,
  input  logic [ozd_pkg::IDX_W-1:0]            read_index_i,
  output logic                                 done_o,
  output logic                                 inserted_o,
  output logic [ozd_pkg::ECNT_W-1:0]           entry_count_o,
  output logic signed [ozd_pkg::ZONE_W-1:0]    read_zone_o,
  output logic                                 read_valid_o,
  input  logic                                 cfg_we_i,
  input  logic [ozd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ozd_pkg::ZONE_W-1:0]           cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;  // range check of the observed zone
  localparam logic [2:0] S_SCAN   = 3'd2;  // issue read of next list entry
  localparam logic [2:0] S_CMP    = 3'd3;  // compare read entry with the zone
  localparam logic [2:0] S_WRITE  = 3'd4;  // append the new zone
  localparam logic [2:0] S_RDISS  = 3'd5;  // issue read for a read item
  localparam logic [2:0] S_RDWAIT = 3'd6;  // return read data

  logic [2:0] state_q, state_d;

  // List bookkeeping: oldest slot and fill count.
  logic [ozd_pkg::ADDR_W-1:0] head_q, head_d;
  logic [ozd_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ozd_pkg::CNT_W-1:0]  scan_q, scan_d;

  // Held item.
  logic signed [ozd_pkg::ZONE_W-1:0] zone_q, zone_d;
  logic [ozd_pkg::IDX_W-1:0]         idx_q, idx_d;

  // Result registers.
  logic                              done_q, done_d;
  logic                              inserted_q, inserted_d;
  logic [ozd_pkg::ECNT_W-1:0]        ecount_q, ecount_d;
  logic signed [ozd_pkg::ZONE_W-1:0] rzone_q, rzone_d;
  logic                              rvalid_q, rvalid_d;

  // RAM access.
  logic                              ram_we;
  logic [ozd_pkg::ADDR_W-1:0]        ram_waddr;
  logic [ozd_pkg::ZONE_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [ozd_pkg::ADDR_W-1:0]        ram_raddr;
  logic [ozd_pkg::ZONE_W-1:0]        ram_rdata;

  logic in_range;
  logic list_full;

  ozd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .zone_i      (zone_q),
    .in_range_o  (in_range)
  );

  ozd_ram #(
    .DEPTH (ozd_pkg::MAX_ENTRIES),
    .WIDTH (ozd_pkg::ZONE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign list_full = (count_q == ozd_pkg::CNT_W'(ozd_pkg::MAX_ENTRIES));
  assign ram_wdata = zone_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    scan_d     = scan_q;
    zone_d     = zone_q;
    idx_d      = idx_q;
    done_d     = 1'b0;
    inserted_d = inserted_q;
    ecount_d   = ecount_q;
    rzone_d    = rzone_q;
    rvalid_d   = rvalid_q;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    ram_re     = 1'b0;
    ram_raddr  = head_q;

    case (state_q)
      S_IDLE: begin
        // Take the item and hold its fields for the whole operation.
        if (start) begin
          zone_d  = zone_i;
          idx_d   = read_index_i;
          state_d = (operation_i == ozd_pkg::OP_READ) ? S_RDISS : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!in_range) begin
          done_d     = 1'b1;
          inserted_d = 1'b0;
          ecount_d   = ozd_pkg::count_out(count_q);
          rzone_d    = '0;
          rvalid_d   = 1'b0;
          state_d    = S_IDLE;
        end else begin
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Whole list compared without a hit: append.
        if (scan_q == count_q) begin
          state_d = S_WRITE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ozd_pkg::wrap_addr(head_q, scan_q);
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        if (ram_rdata == zone_q) begin
          // Already listed: drop the observation.
          done_d     = 1'b1;
          inserted_d = 1'b0;
          ecount_d   = ozd_pkg::count_out(count_q);
          rzone_d    = '0;
          rvalid_d   = 1'b0;
          state_d    = S_IDLE;
        end else begin
          scan_d  = scan_q + ozd_pkg::CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (list_full) begin
          // Overwrite the oldest slot and advance the head past it.
          ram_waddr = head_q;
          head_d    = ozd_pkg::wrap_addr(head_q, ozd_pkg::CNT_W'(1));
        end else begin
          ram_waddr = ozd_pkg::wrap_addr(head_q, count_q);
          count_d   = count_q + ozd_pkg::CNT_W'(1);
        end
        done_d     = 1'b1;
        inserted_d = 1'b1;
        ecount_d   = ozd_pkg::count_out(count_d);
        rzone_d    = '0;
        rvalid_d   = 1'b0;
        state_d    = S_IDLE;
      end
      S_RDISS: begin
        if (ozd_pkg::idx_below(idx_q, count_q)) begin
          ram_re    = 1'b1;
          ram_raddr = ozd_pkg::wrap_addr(head_q, ozd_pkg::CNT_W'(idx_q));
          state_d   = S_RDWAIT;
        end else begin
          done_d     = 1'b1;
          inserted_d = 1'b0;
          ecount_d   = ozd_pkg::count_out(count_q);
          rzone_d    = '0;
          rvalid_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_RDWAIT: begin
        done_d     = 1'b1;
        inserted_d = 1'b0;
        ecount_d   = ozd_pkg::count_out(count_q);
        rzone_d    = $signed(ram_rdata);
        rvalid_d   = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zone_q     <= zone_d;
    idx_q      <= idx_d;
    inserted_q <= inserted_d;
    ecount_q   <= ecount_d;
    rzone_q    <= rzone_d;
    rvalid_q   <= rvalid_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign inserted_o    = inserted_q;
  assign entry_count_o = ecount_q;
  assign read_zone_o   = rzone_q;
  assign read_valid_o  = rvalid_q;

endmodule

// ===== sv/ozd_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read port.
module ozd_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ozd_cfg.sv =====
`timescale 1ns / 1ps
// Zone range registers and the range check of the held zone.
module ozd_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ozd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ozd_pkg::ZONE_W-1:0]           cfg_data_i,
  input  logic signed [ozd_pkg::ZONE_W-1:0]    zone_i,
  output logic                                 in_range_o
);

  logic signed [ozd_pkg::ZONE_W-1:0] zone_min_q, zone_min_d;
  logic signed [ozd_pkg::ZONE_W-1:0] zone_max_q, zone_max_d;

  always_comb begin
    zone_min_d = zone_min_q;
    zone_max_d = zone_max_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ozd_pkg::REG_ZONE_MIN: zone_min_d = $signed(cfg_data_i);
        ozd_pkg::REG_ZONE_MAX: zone_max_d = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_min_q <= ozd_pkg::ZONE_MIN_RST;
      zone_max_q <= ozd_pkg::ZONE_MAX_RST;
    end else begin
      zone_min_q <= zone_min_d;
      zone_max_q <= zone_max_d;
    end
  end

  // An empty range (min above max) fails at least one compare for every zone.
  assign in_range_o = (zone_i >= zone_min_q) && (zone_i <= zone_max_q);

endmodule

// ===== sv/ozd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the observed zone dedup FIFO, bound to the top level.
module ozd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               done_o,
  input logic                               inserted_o,
  input logic [ozd_pkg::ECNT_W-1:0]         entry_count_o,
  input logic                               read_valid_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result ends the item: busy is low while it shows and was high before.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result shown outside the end of an item");

  // Results are one-cycle strobes, one item at a time.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A read never inserts.
  a_read_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && read_valid_o) |-> !inserted_o)
    else $error("read result flagged an insert");

  // The count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_count_o <= ozd_pkg::ECNT_W'(ozd_pkg::MAX_ENTRIES)))
    else $error("entry count above list depth");

endmodule

bind observed_zone_dedup_fifo ozd_checker u_ozd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .inserted_o    (inserted_o),
  .entry_count_o (entry_count_o),
  .read_valid_o  (read_valid_o)
);
